[hdl/pfc_pkg.sv]
// ----------------------------------------------------------------------------
// pfc_pkg
// Types, format codes and colour conversion functions for the pixel codec.
// ----------------------------------------------------------------------------
package pfc_pkg;

  typedef enum logic [1:0] {
    CMD_PACK   = 2'd0,
    CMD_UNPACK = 2'd1,
    CMD_PALWR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_FORMAT = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_STRIDE = 2'd3
  } reg_e;

  localparam logic [4:0] FMT_A8R8G8B8 = 5'd1;
  localparam logic [4:0] FMT_A8B8G8R8 = 5'd2;
  localparam logic [4:0] FMT_X8R8G8B8 = 5'd3;
  localparam logic [4:0] FMT_X8B8G8R8 = 5'd4;
  localparam logic [4:0] FMT_R8G8B8   = 5'd5;
  localparam logic [4:0] FMT_B8G8R8   = 5'd6;
  localparam logic [4:0] FMT_A4R4G4B4 = 5'd7;
  localparam logic [4:0] FMT_A4B4G4R4 = 5'd8;
  localparam logic [4:0] FMT_X4R4G4B4 = 5'd9;
  localparam logic [4:0] FMT_X4B4G4R4 = 5'd10;
  localparam logic [4:0] FMT_A1R5G5B5 = 5'd11;
  localparam logic [4:0] FMT_A1B5G5R5 = 5'd12;
  localparam logic [4:0] FMT_X1R5G5B5 = 5'd13;
  localparam logic [4:0] FMT_X1B5G5R5 = 5'd14;
  localparam logic [4:0] FMT_R5G6B5   = 5'd15;
  localparam logic [4:0] FMT_B5G6R5   = 5'd16;
  localparam logic [4:0] FMT_PAL8     = 5'd17;
  localparam logic [4:0] FMT_PAL4     = 5'd18;
  localparam logic [4:0] FMT_IDX32    = 5'd19;
  localparam logic [4:0] FMT_IDX24    = 5'd20;
  localparam logic [4:0] FMT_IDX16    = 5'd21;
  localparam logic [4:0] FMT_IDX8     = 5'd22;
  localparam logic [4:0] FMT_IDX4     = 5'd23;
  localparam logic [4:0] FMT_MONO     = 5'd24;

  localparam logic [31:0] ALPHA_OPAQUE = 32'hff000000;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] color;
    logic [7:0]  palette_index;
    logic [31:0] stored_raw;
  } pix_in_t;

  typedef struct packed {
    logic        in_bounds;
    logic        write_enable;
    logic [31:0] byte_address;
    logic [2:0]  bit_offset;
    logic [5:0]  element_bits;
    logic [31:0] packed_value;
    logic [31:0] color_out;
  } pix_out_t;

  function automatic logic [5:0] fmt_bits(input logic [4:0] f);
    logic [5:0] b;
    b = 6'd0;
    if (f >= FMT_A8R8G8B8 && f <= FMT_X8B8G8R8) b = 6'd32;
    else if (f == FMT_R8G8B8 || f == FMT_B8G8R8) b = 6'd24;
    else if (f >= FMT_A4R4G4B4 && f <= FMT_B5G6R5) b = 6'd16;
    else if (f == FMT_PAL8 || f == FMT_IDX8) b = 6'd8;
    else if (f == FMT_PAL4 || f == FMT_IDX4) b = 6'd4;
    else if (f == FMT_IDX32) b = 6'd32;
    else if (f == FMT_IDX24) b = 6'd24;
    else if (f == FMT_IDX16) b = 6'd16;
    else if (f == FMT_MONO) b = 6'd1;
    return b;
  endfunction

  function automatic logic [31:0] swap_rb(input logic [31:0] c);
    return {c[31:24], c[7:0], c[15:8], c[23:16]};
  endfunction

  function automatic logic is_palette(input logic [4:0] f);
    return (f == FMT_PAL8) || (f == FMT_PAL4) || (f == FMT_MONO);
  endfunction

  function automatic logic [31:0] pack_color(input logic [4:0] f, input logic [31:0] c);
    logic [31:0] r;
    r = '0;
    if (f == FMT_A8R8G8B8 || f == FMT_IDX32) r = c;
    else if (f == FMT_A8B8G8R8) r = swap_rb(c);
    else if (f == FMT_X8R8G8B8 || f == FMT_R8G8B8 || f == FMT_IDX24) r = {8'h0, c[23:0]};
    else if (f == FMT_X8B8G8R8 || f == FMT_B8G8R8) r = {8'h0, c[7:0], c[15:8], c[23:16]};
    else if (f == FMT_A4R4G4B4) r = {16'h0, c[31:28], c[23:20], c[15:12], c[7:4]};
    else if (f == FMT_A4B4G4R4) r = {16'h0, c[31:28], c[7:4], c[15:12], c[23:20]};
    else if (f == FMT_X4R4G4B4) r = {20'h0, c[23:20], c[15:12], c[7:4]};
    else if (f == FMT_X4B4G4R4) r = {20'h0, c[7:4], c[15:12], c[23:20]};
    else if (f == FMT_A1R5G5B5) r = {16'h0, c[31], c[23:19], c[15:11], c[7:3]};
    else if (f == FMT_A1B5G5R5) r = {16'h0, c[31], c[7:3], c[15:11], c[23:19]};
    else if (f == FMT_X1R5G5B5) r = {17'h0, c[23:19], c[15:11], c[7:3]};
    else if (f == FMT_X1B5G5R5) r = {17'h0, c[7:3], c[15:11], c[23:19]};
    else if (f == FMT_R5G6B5) r = {16'h0, c[23:19], c[15:10], c[7:3]};
    else if (f == FMT_B5G6R5) r = {16'h0, c[7:3], c[15:10], c[23:19]};
    else if (f == FMT_IDX16) r = {16'h0, c[15:0]};
    else if (f == FMT_PAL8 || f == FMT_IDX8) r = {24'h0, c[7:0]};
    else if (f == FMT_PAL4 || f == FMT_IDX4) r = {28'h0, c[3:0]};
    else if (f == FMT_MONO) r = {31'h0, |c};
    return r;
  endfunction

  // direct-colour expansion; palette formats are resolved elsewhere
  function automatic logic [31:0] unpack_direct(input logic [4:0] f, input logic [31:0] v);
    logic [31:0] r;
    r = '0;
    if (f == FMT_A8R8G8B8 || f == FMT_IDX32) r = v;
    else if (f == FMT_A8B8G8R8) r = swap_rb(v);
    else if (f == FMT_X8R8G8B8 || f == FMT_R8G8B8) r = ALPHA_OPAQUE | v;
    else if (f == FMT_X8B8G8R8) r = {8'h0, v[7:0], v[15:8], v[23:16]};
    else if (f == FMT_B8G8R8) r = {8'hff, v[7:0], v[15:8], v[23:16]};
    else if (f == FMT_A4R4G4B4)
      r = {v[15:12], 4'h0, v[11:8], 4'h0, v[7:4], 4'h0, v[3:0], 4'h0};
    else if (f == FMT_A4B4G4R4)
      r = {v[15:12], 4'h0, v[3:0], 4'h0, v[7:4], 4'h0, v[11:8], 4'h0};
    else if (f == FMT_X4R4G4B4)
      r = {8'hff, v[11:8], 4'h0, v[7:4], 4'h0, v[3:0], 4'h0};
    else if (f == FMT_X4B4G4R4)
      r = {8'hff, v[3:0], 4'h0, v[7:4], 4'h0, v[11:8], 4'h0};
    else if (f == FMT_A1R5G5B5)
      r = {v[15], 7'h0, v[14:10], 3'h0, v[9:5], 3'h0, v[4:0], 3'h0};
    else if (f == FMT_A1B5G5R5)
      r = {v[15], 7'h0, v[4:0], 3'h0, v[9:5], 3'h0, v[14:10], 3'h0};
    else if (f == FMT_X1R5G5B5)
      r = {8'hff, v[14:10], 3'h0, v[9:5], 3'h0, v[4:0], 3'h0};
    else if (f == FMT_X1B5G5R5)
      r = {8'hff, v[4:0], 3'h0, v[9:5], 3'h0, v[14:10], 3'h0};
    else if (f == FMT_R5G6B5)
      r = {8'hff, v[15:11], 3'h0, v[10:5], 2'h0, v[4:0], 3'h0};
    else if (f == FMT_B5G6R5)
      r = {8'hff, v[4:0], 3'h0, v[10:5], 2'h0, v[15:11], 3'h0};
    else if (f == FMT_IDX24 || f == FMT_IDX16 || f == FMT_IDX8 || f == FMT_IDX4) r = v;
    return r;
  endfunction

endpackage

[hdl/pfc_ram.sv]
// ----------------------------------------------------------------------------
// pfc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pfc_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/pfc_addr.sv]
// ----------------------------------------------------------------------------
// pfc_addr
// Stage one: bounds check, address generation, packing, element extract and direct unpack.
// ----------------------------------------------------------------------------
module pfc_addr (
  input  pfc_pkg::pix_in_t  in_i,
  input  logic [4:0]        fmt_i,
  input  logic [14:0]       width_i,
  input  logic [14:0]       height_i,
  input  logic [15:0]       stride_i,
  output pfc_pkg::pix_out_t res_o,
  output logic [31:0]       elem_o
);
  import pfc_pkg::*;

  logic [5:0]  bits;
  logic        known, inb, act;
  logic [14:0] ux, uy;
  logic [31:0] off, raw;
  logic [2:0]  boff;

  always_comb begin
    bits  = fmt_bits(fmt_i);
    known = bits != 6'd0;
    ux    = in_i.x[14:0];
    uy    = in_i.y[14:0];
    inb   = !in_i.x[15] && !in_i.y[15] && (ux < width_i) && (uy < height_i);
    act   = (in_i.command == CMD_PACK) || (in_i.command == CMD_UNPACK);
    boff  = 3'd0;
    off   = 32'd0;
    if (bits == 6'd1) begin
      off  = {20'h0, ux[14:3]};
      boff = 3'd7 - ux[2:0];
    end else if (bits == 6'd4) begin
      off  = {18'h0, ux[14:1]};
      boff = {ux[0], 2'b00};
    end else begin
      off = {17'h0, ux} * {29'h0, bits[5:3]};
    end
    raw = in_i.stored_raw;
    elem_o = '0;
    if (inb) begin
      unique case (bits)
        6'd32:   elem_o = raw;
        6'd24:   elem_o = {8'h0, raw[23:0]};
        6'd16:   elem_o = {16'h0, raw[15:0]};
        6'd8:    elem_o = {24'h0, raw[7:0]};
        6'd4:    elem_o = {28'h0, boff[2] ? raw[7:4] : raw[3:0]};
        6'd1:    elem_o = {31'h0, raw[boff]};
        default: elem_o = '0;
      endcase
    end
    res_o = '0;
    if (act) begin
      res_o.in_bounds    = inb;
      res_o.element_bits = bits;
      if (inb && known) begin
        res_o.byte_address = {17'h0, uy} * {16'h0, stride_i} + off;
        res_o.bit_offset   = boff;
      end
      if (in_i.command == CMD_PACK) begin
        res_o.packed_value = pack_color(fmt_i, in_i.color);
        res_o.write_enable = inb && known;
      end else begin
        res_o.color_out = unpack_direct(fmt_i, elem_o);
      end
    end
  end

endmodule

[hdl/pixel_format_codec_core.sv]
// ----------------------------------------------------------------------------
// pixel_format_codec_core
// Framebuffer pixel pack/unpack unit with a palette held in a synchronous RAM.
// ----------------------------------------------------------------------------
// The result is registered in stage 2, after stage 1 and the palette read.
// Throughput: one transaction per cycle while the output is not stalled.
// A palette write lands at its accepting edge, so a later read sees it.
// Reset clears the configuration registers and output valid, and marks every palette entry invalid (reads zero).
module pixel_format_codec_core #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pfc_pkg::pix_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pfc_pkg::pix_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);
  import pfc_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [4:0]  fmt_q;
  logic [14:0] width_q, height_q;
  logic [15:0] stride_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= '0; width_q <= '0; height_q <= '0; stride_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_FORMAT: fmt_q    <= cfg_data_i[4:0];
        REG_WIDTH:  width_q  <= cfg_data_i[14:0];
        REG_HEIGHT: height_q <= cfg_data_i[14:0];
        REG_STRIDE: stride_q <= cfg_data_i;
        default:    fmt_q    <= fmt_q;
      endcase
    end
  end

  // stage 1
  pix_out_t    s1_res;
  logic [31:0] s1_elem;
  pfc_addr u_addr (
    .in_i(in_data_i), .fmt_i(fmt_q), .width_i(width_q), .height_i(height_q),
    .stride_i(stride_q), .res_o(s1_res), .elem_o(s1_elem)
  );

  logic adv, acc;
  logic s2_valid_q;
  assign adv = !s2_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign acc = in_valid_i && adv;

  // palette write and read
  logic          pal_we, rd_hit, rd_en;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rdata;
  logic [PALETTE_DEPTH-1:0] pvalid_q;
  assign pal_we = acc && (in_data_i.command == CMD_PALWR) &&
                  ({24'h0, in_data_i.palette_index} < 32'(PALETTE_DEPTH));
  assign rd_hit = (s1_elem < 32'(PALETTE_DEPTH));
  assign rd_addr = s1_elem[AW-1:0];
  assign rd_en = acc;

  pfc_ram #(.Width(32), .Depth(PALETTE_DEPTH)) u_pal (
    .clk_i(clk_i), .we_i(pal_we), .waddr_i(in_data_i.palette_index[AW-1:0]),
    .wdata_i(in_data_i.color), .re_i(rd_en), .raddr_i(rd_addr), .rdata_o(rdata)
  );

  pix_out_t s2_res_q;
  logic     s2_pal_q, s2_hit_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      pvalid_q   <= '0;
    end else begin
      if (adv) s2_valid_q <= in_valid_i;
      if (pal_we) pvalid_q[in_data_i.palette_index[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s2_res_q <= s1_res;
      s2_pal_q <= (in_data_i.command == CMD_UNPACK) && is_palette(fmt_q);
      s2_hit_q <= rd_hit && pvalid_q[rd_addr];
    end
  end

  // palette resolution for palette-format unpacks; a miss or an invalid entry gives zero
  always_comb begin
    out_data_o = s2_res_q;
    if (s2_pal_q) out_data_o.color_out = s2_hit_q ? rdata : 32'h0;
  end
  assign out_valid_o = s2_valid_q;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");
  a_pack_noc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.write_enable |-> out_data_o.color_out == 32'h0)
    else $error("pack result has a colour");

endmodule

[test/pixel_format_codec_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_codec_checker
// Watches the pixel codec channels, keeps its own palette and register copy,
// predicts every result and compares it field by field in order.
// ----------------------------------------------------------------------------
module pixel_format_codec_checker #(
  parameter int PAL_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  pfc_pkg::pix_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  pfc_pkg::pix_out_t out_data_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  import pfc_pkg::*;

  logic [31:0] pal_mirror [PAL_DEPTH];
  logic [4:0]  fmt_q;
  logic [14:0] width_q, height_q;
  logic [15:0] stride_q;
  pix_out_t    expected_q [$];
  int          fail_cnt = 0;

  assign pending_o = expected_q.size();
  assign fail_count_o = fail_cnt;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_cnt++;
  endtask

  function automatic logic [5:0] elem_width(input logic [4:0] f);
    if (f >= FMT_A8R8G8B8 && f <= FMT_X8B8G8R8) return 6'd32;
    if (f == FMT_R8G8B8 || f == FMT_B8G8R8) return 6'd24;
    if (f >= FMT_A4R4G4B4 && f <= FMT_B5G6R5) return 6'd16;
    if (f == FMT_PAL8 || f == FMT_IDX8) return 6'd8;
    if (f == FMT_PAL4 || f == FMT_IDX4) return 6'd4;
    if (f == FMT_IDX32) return 6'd32;
    if (f == FMT_IDX24) return 6'd24;
    if (f == FMT_IDX16) return 6'd16;
    if (f == FMT_MONO) return 6'd1;
    return 6'd0;
  endfunction

  function automatic logic [31:0] rb_swap(input logic [31:0] c);
    return (c & 32'hff00ff00) | ((c >> 16) & 32'hff) | ((c << 16) & 32'hff0000);
  endfunction

  function automatic logic [31:0] lookup(input logic [31:0] i);
    return (i < PAL_DEPTH) ? pal_mirror[i] : 32'h0;
  endfunction

  function automatic logic [31:0] encode_colour(input logic [4:0] f, input logic [31:0] c);
    case (f)
      FMT_A8R8G8B8, FMT_IDX32: return c;
      FMT_A8B8G8R8: return rb_swap(c);
      FMT_X8R8G8B8, FMT_R8G8B8, FMT_IDX24: return c & 32'h00ffffff;
      FMT_X8B8G8R8, FMT_B8G8R8: return rb_swap(c) & 32'h00ffffff;
      FMT_A4R4G4B4: return ((c >> 16) & 32'hf000) | ((c >> 12) & 32'h0f00)
                         | ((c >> 8) & 32'h00f0) | ((c >> 4) & 32'h000f);
      FMT_A4B4G4R4: return ((c >> 16) & 32'hf000) | ((c >> 20) & 32'h000f)
                         | ((c >> 8) & 32'h00f0) | ((c << 4) & 32'h0f00);
      FMT_X4R4G4B4: return ((c >> 12) & 32'h0f00) | ((c >> 8) & 32'h00f0)
                         | ((c >> 4) & 32'h000f);
      FMT_X4B4G4R4: return ((c >> 20) & 32'h000f) | ((c >> 8) & 32'h00f0)
                         | ((c << 4) & 32'h0f00);
      FMT_A1R5G5B5: return ((c >> 16) & 32'h8000) | ((c >> 9) & 32'h7c00)
                         | ((c >> 6) & 32'h03e0) | ((c >> 3) & 32'h001f);
      FMT_A1B5G5R5: return ((c >> 16) & 32'h8000) | ((c >> 19) & 32'h001f)
                         | ((c >> 6) & 32'h03e0) | ((c << 7) & 32'h7c00);
      FMT_X1R5G5B5: return ((c >> 9) & 32'h7c00) | ((c >> 6) & 32'h03e0)
                         | ((c >> 3) & 32'h001f);
      FMT_X1B5G5R5: return ((c >> 19) & 32'h001f) | ((c >> 6) & 32'h03e0)
                         | ((c << 7) & 32'h7c00);
      FMT_R5G6B5: return ((c >> 8) & 32'hf800) | ((c >> 5) & 32'h07e0)
                       | ((c >> 3) & 32'h001f);
      FMT_B5G6R5: return ((c >> 19) & 32'h001f) | ((c >> 5) & 32'h07e0)
                       | ((c << 8) & 32'hf800);
      FMT_IDX16: return c & 32'hffff;
      FMT_PAL8, FMT_IDX8: return c & 32'hff;
      FMT_PAL4, FMT_IDX4: return c & 32'hf;
      FMT_MONO: return (c != 0) ? 32'h1 : 32'h0;
      default: return 32'h0;
    endcase
  endfunction

  function automatic logic [31:0] decode_colour(input logic [4:0] f, input logic [31:0] v);
    case (f)
      FMT_A8R8G8B8, FMT_IDX32: return v;
      FMT_A8B8G8R8: return rb_swap(v);
      FMT_X8R8G8B8, FMT_R8G8B8: return 32'hff000000 | v;
      FMT_X8B8G8R8: return rb_swap(v) & 32'h00ffffff;
      FMT_B8G8R8: return 32'hff000000 | (rb_swap(v) & 32'h00ffffff);
      FMT_A4R4G4B4: return ((v & 32'hf000) << 16) | ((v & 32'h0f00) << 12)
                         | ((v & 32'h00f0) << 8) | ((v & 32'h000f) << 4);
      FMT_A4B4G4R4: return ((v & 32'hf000) << 16) | ((v & 32'h000f) << 20)
                         | ((v & 32'h00f0) << 8) | ((v & 32'h0f00) >> 4);
      FMT_X4R4G4B4: return ((v & 32'h0f00) << 12) | ((v & 32'h00f0) << 8)
                         | ((v & 32'h000f) << 4) | 32'hff000000;
      FMT_X4B4G4R4: return ((v & 32'h000f) << 20) | ((v & 32'h00f0) << 8)
                         | ((v & 32'h0f00) >> 4) | 32'hff000000;
      FMT_A1R5G5B5: return ((v & 32'h8000) << 16) | ((v & 32'h7c00) << 9)
                         | ((v & 32'h03e0) << 6) | ((v & 32'h001f) << 3);
      FMT_A1B5G5R5: return ((v & 32'h8000) << 16) | ((v & 32'h001f) << 19)
                         | ((v & 32'h03e0) << 6) | ((v & 32'h7c00) >> 7);
      FMT_X1R5G5B5: return ((v & 32'h7c00) << 9) | ((v & 32'h03e0) << 6)
                         | ((v & 32'h001f) << 3) | 32'hff000000;
      FMT_X1B5G5R5: return ((v & 32'h001f) << 19) | ((v & 32'h03e0) << 6)
                         | ((v & 32'h7c00) >> 7) | 32'hff000000;
      FMT_R5G6B5: return ((v & 32'hf800) << 8) | ((v & 32'h07e0) << 5)
                       | ((v & 32'h001f) << 3) | 32'hff000000;
      FMT_B5G6R5: return ((v & 32'h001f) << 19) | ((v & 32'h07e0) << 5)
                       | ((v & 32'hf800) >> 8) | 32'hff000000;
      FMT_PAL8, FMT_PAL4, FMT_MONO: return lookup(v);
      FMT_IDX24, FMT_IDX16, FMT_IDX8, FMT_IDX4: return v;
      default: return 32'h0;
    endcase
  endfunction

  // work out the result of one transaction and update the palette copy
  function automatic pix_out_t predict_pixel(input pix_in_t t);
    pix_out_t r;
    logic [5:0] bits;
    logic signed [15:0] sx, sy;
    logic inb;
    logic [31:0] off, elem;
    r = '0;
    bits = elem_width(fmt_q);
    sx = t.x;
    sy = t.y;
    elem = 0;
    if (t.command == CMD_PALWR) begin
      if (t.palette_index < PAL_DEPTH) pal_mirror[t.palette_index] = t.color;
      return r;
    end
    if (t.command == CMD_NOP) return r;
    inb = (sx >= 0) && (sy >= 0) && (sx < $signed({1'b0, width_q}))
          && (sy < $signed({1'b0, height_q}));
    r.in_bounds = inb;
    r.element_bits = bits;
    if (inb && bits != 0) begin
      if (bits == 1) begin
        off = t.x >> 3;
        r.bit_offset = 3'd7 - t.x[2:0];
      end else if (bits == 4) begin
        off = t.x >> 1;
        r.bit_offset = {t.x[0], 2'b00};
      end else begin
        off = 32'(t.x) * (bits >> 3);
      end
      r.byte_address = 32'(t.y) * 32'(stride_q) + off;
    end
    if (t.command == CMD_PACK) begin
      r.packed_value = encode_colour(fmt_q, t.color);
      r.write_enable = inb && bits != 0;
    end else if (bits != 0) begin
      if (inb) begin
        case (bits)
          6'd32: elem = t.stored_raw;
          6'd24: elem = t.stored_raw & 32'hffffff;
          6'd16: elem = t.stored_raw & 32'hffff;
          6'd8:  elem = t.stored_raw & 32'hff;
          6'd4:  elem = (32'(t.stored_raw[7:0]) >> r.bit_offset) & 32'hf;
          default: elem = (32'(t.stored_raw[7:0]) >> r.bit_offset) & 32'h1;
        endcase
      end
      r.color_out = decode_colour(fmt_q, elem);
    end
    return r;
  endfunction

  // register copy, palette copy, prediction and comparison
  always_ff @(posedge clk_i or negedge rst_ni) begin
    pix_out_t w;
    if (!rst_ni) begin
      fmt_q <= '0;
      width_q <= '0;
      height_q <= '0;
      stride_q <= '0;
      for (int i = 0; i < PAL_DEPTH; i++) pal_mirror[i] = '0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_index_i))
          REG_FORMAT: fmt_q <= cfg_data_i[4:0];
          REG_WIDTH:  width_q <= cfg_data_i[14:0];
          REG_HEIGHT: height_q <= cfg_data_i[14:0];
          REG_STRIDE: stride_q <= cfg_data_i;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(predict_pixel(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          w = expected_q.pop_front();
          if (out_data_i.in_bounds !== w.in_bounds)
            report_mismatch("in_bounds", out_data_i.in_bounds, w.in_bounds);
          if (out_data_i.write_enable !== w.write_enable)
            report_mismatch("write_enable", out_data_i.write_enable, w.write_enable);
          if (out_data_i.byte_address !== w.byte_address)
            report_mismatch("byte_address", out_data_i.byte_address, w.byte_address);
          if (out_data_i.bit_offset !== w.bit_offset)
            report_mismatch("bit_offset", out_data_i.bit_offset, w.bit_offset);
          if (out_data_i.element_bits !== w.element_bits)
            report_mismatch("element_bits", out_data_i.element_bits, w.element_bits);
          if (out_data_i.packed_value !== w.packed_value)
            report_mismatch("packed_value", out_data_i.packed_value, w.packed_value);
          if (out_data_i.color_out !== w.color_out)
            report_mismatch("color_out", out_data_i.color_out, w.color_out);
        end
      end
    end
  end

endmodule

[test/pixel_format_codec_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_codec_core_tb
// Drives pack, unpack and palette transactions through a range of formats
// and bitmap sizes with random bursts and output stalls; the checker judges.
// ----------------------------------------------------------------------------
module pixel_format_codec_core_tb;
  import pfc_pkg::*;

  logic     clk, rst_n;
  logic     in_valid, in_stall, out_valid, out_stall;
  pix_in_t  in_data;
  pix_out_t out_data;
  logic     cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  int       fail_count, pending;
  int       burst_left;

  pixel_format_codec_core u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  pixel_format_codec_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver stall pattern: light stalling, a calm stretch, heavy stalling, then light again
  initial begin
    int phase;
    out_stall = 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (phase[8:7] == 2'b01) out_stall <= 1'b0;
      else if (phase[8:7] == 2'b10) out_stall <= ($urandom_range(0, 3) != 0);
      else out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic write_reg(input reg_e idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // drop valid and wait until every accepted transaction has its result
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic setup_bitmap(input logic [4:0] f, input logic [15:0] w,
                              input logic [15:0] h, input logic [15:0] s);
    wait_drained();
    write_reg(REG_FORMAT, {11'd0, f});
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_STRIDE, s);
    cfg_we <= 1'b0;
  endtask

  // one transaction, with burst/gap shaping before it
  task automatic send_pixel(input cmd_e c, input logic [15:0] px, input logic [15:0] py,
                            input logic [31:0] col, input logic [7:0] idx,
                            input logic [31:0] raw);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= '{command: c, x: px, y: py, color: col, palette_index: idx,
                 stored_raw: raw};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic random_pixel(input logic [15:0] w, input logic [15:0] h);
    int sel;
    cmd_e c;
    logic [15:0] px, py;
    sel = $urandom_range(0, 9);
    c = (sel < 4) ? CMD_PACK : (sel < 8) ? CMD_UNPACK : (sel < 9) ? CMD_PALWR : CMD_NOP;
    if ($urandom_range(0, 5) == 0) begin
      px = $urandom;
      py = $urandom;
    end else begin
      px = (w == 0) ? 16'd0 : $urandom_range(0, w - 1);
      py = (h == 0) ? 16'd0 : $urandom_range(0, h - 1);
    end
    send_pixel(c, px, py, $urandom, $urandom, $urandom);
  endtask

  initial begin
    logic [15:0] w, h;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_FORMAT;
    cfg_data = '0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: unknown formats (0 after reset, 31), palette writes, mono, palette 4/8, A1B5G5R5
    send_pixel(CMD_PACK, 16'd0, 16'd0, 32'hffffffff, 8'd0, 32'hffffffff);
    send_pixel(CMD_UNPACK, 16'd0, 16'd0, 32'h0, 8'd0, 32'hffffffff);
    send_pixel(CMD_NOP, 16'hffff, 16'hffff, 32'hffffffff, 8'hff, 32'hffffffff);
    send_pixel(CMD_PALWR, 16'd0, 16'd0, 32'h11223344, 8'd0, 32'd0);
    send_pixel(CMD_PALWR, 16'd0, 16'd0, 32'hdeadbeef, 8'd1, 32'd0);
    send_pixel(CMD_PALWR, 16'd0, 16'd0, 32'hcafef00d, 8'd255, 32'd0);
    setup_bitmap(FMT_MONO, 16'h7fff, 16'h7fff, 16'hffff);
    send_pixel(CMD_PACK, 16'd9, 16'd3, 32'h0, 8'd0, 32'd0);
    send_pixel(CMD_PACK, 16'h7ffe, 16'h7ffe, 32'h1, 8'd0, 32'd0);
    send_pixel(CMD_UNPACK, 16'd0, 16'd0, 32'd0, 8'd0, 32'h80);
    send_pixel(CMD_UNPACK, 16'd7, 16'd0, 32'd0, 8'd0, 32'h01);
    send_pixel(CMD_UNPACK, 16'h8000, 16'd0, 32'd0, 8'd0, 32'hff);
    send_pixel(CMD_UNPACK, 16'd0, 16'h7fff, 32'd0, 8'd0, 32'hff);
    setup_bitmap(FMT_PAL4, 16'd8, 16'd8, 16'd4);
    send_pixel(CMD_UNPACK, 16'd1, 16'd2, 32'd0, 8'd0, 32'h1f);
    send_pixel(CMD_UNPACK, 16'd0, 16'd2, 32'd0, 8'd0, 32'hf1);
    send_pixel(CMD_PACK, 16'd3, 16'd7, 32'hfffffff5, 8'd0, 32'd0);
    setup_bitmap(FMT_PAL8, 16'd4, 16'd4, 16'd4);
    send_pixel(CMD_UNPACK, 16'd3, 16'd3, 32'd0, 8'd0, 32'h000000ff);
    setup_bitmap(FMT_A1B5G5R5, 16'd0, 16'd0, 16'd0);
    send_pixel(CMD_PACK, 16'd0, 16'd0, 32'h80f8f8f8, 8'd0, 32'd0);
    setup_bitmap(5'd31, 16'd10, 16'd10, 16'd10);
    send_pixel(CMD_UNPACK, 16'd1, 16'd1, 32'd1, 8'd0, 32'hffffffff);

    // wait for every result before the random part
    wait_drained();

    // random: formats drawn from the whole format code range, a range of sizes; small bitmaps mostly
    for (int blk = 0; blk < 30; blk++) begin
      w = ($urandom_range(0, 7) == 0) ? 16'h7fff : $urandom_range(0, 40);
      h = ($urandom_range(0, 7) == 0) ? 16'h7fff : $urandom_range(0, 40);
      setup_bitmap(5'($urandom_range(0, 31)), w, h,
                   ($urandom_range(0, 5) == 0) ? 16'hffff : 16'($urandom_range(0, 200)));
      for (int k = 0; k < 15; k++) random_pixel(w, h);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
